/* sv/iee_pkg.sv */
// shared types and constants of the ising energy evaluator
package iee_pkg;

  // field widths
  localparam int OPCODE_W     = 1;
  localparam int IDX_FIELD_W  = 6;
  localparam int COUPLING_W   = 16;
  localparam int SPIN_W       = 64;
  localparam int SPIN_IDX_W   = 6;
  localparam int ENERGY_W     = 27;
  localparam int NUM_SPINS_W  = 7;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_EVAL  = 1'b1;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0]   REG_NUM_SPINS   = 1'b0;
  localparam logic [NUM_SPINS_W-1:0] NUM_SPINS_RESET = 7'd64;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // item as it travels through the queue
  typedef struct packed {
    logic                          is_eval;
    logic [IDX_FIELD_W-1:0]        row;
    logic [IDX_FIELD_W-1:0]        col;
    logic signed [COUPLING_W-1:0]  value;
    logic [SPIN_W-1:0]             spins;
  } iee_item_t;

  // status from back to front
  typedef struct packed {
    logic clearing;
  } iee_back_status_t;

  // back end sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN,
    ST_DONE
  } iee_state_e;

endpackage

/* sv/iee_in_if.sv */
// input channel carrying write and evaluate items
interface iee_in_if;
  import iee_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [OPCODE_W-1:0]          opcode;
  logic [IDX_FIELD_W-1:0]       row_index;
  logic [IDX_FIELD_W-1:0]       col_index;
  logic signed [COUPLING_W-1:0] coupling_value;
  logic [SPIN_W-1:0]            spin_bits;

  modport source (output valid, opcode, row_index, col_index, coupling_value, spin_bits,
                  input ready);
  modport sink (input valid, opcode, row_index, col_index, coupling_value, spin_bits,
                output ready);
endinterface

/* sv/iee_out_if.sv */
// output channel carrying energy results
interface iee_out_if;
  import iee_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [ENERGY_W-1:0] energy;

  modport source (output valid, energy, input ready);
  modport sink (input valid, energy, output ready);
endinterface

/* sv/iee_front.sv */
// front end: accepts items, classifies them and drops out-of-range writes
module iee_front #(
  parameter int MAX_SPINS = 64
) (
  iee_in_if.sink                   item_i,
  input  iee_pkg::iee_back_status_t status_i,
  input  logic                     push_ready_i,
  output logic                     push_valid_o,
  output iee_pkg::iee_item_t       push_item_o
);
  import iee_pkg::*;

  logic is_eval;
  logic in_range;

  // classify the incoming item
  assign is_eval  = (item_i.opcode == OP_EVAL);
  assign in_range = ({1'b0, item_i.row_index} < NUM_SPINS_W'(MAX_SPINS)) &&
                    ({1'b0, item_i.col_index} < NUM_SPINS_W'(MAX_SPINS));

  // no items while the store is being cleared
  assign item_i.ready = push_ready_i && !status_i.clearing;

  // out-of-range writes are taken and discarded
  assign push_valid_o = item_i.valid && !status_i.clearing && (is_eval || in_range);

  always_comb begin
    push_item_o.is_eval = is_eval;
    push_item_o.row     = item_i.row_index;
    push_item_o.col     = item_i.col_index;
    push_item_o.value   = item_i.coupling_value;
    push_item_o.spins   = item_i.spin_bits;
  end

endmodule

/* sv/iee_queue.sv */
// two-entry queue between front end and back end
module iee_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  iee_pkg::iee_item_t push_item_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output iee_pkg::iee_item_t pop_item_o,
  input  logic               pop_ready_i
);
  import iee_pkg::*;

  iee_item_t         entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entries_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* sv/iee_back.sv */
// back end: coupling store, pairwise energy sequencer and result register
module iee_back #(
  parameter int MAX_SPINS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [iee_pkg::NUM_SPINS_W-1:0]   num_spins_i,
  input  logic                              q_valid_i,
  input  iee_pkg::iee_item_t                q_item_i,
  output logic                              q_ready_o,
  output iee_pkg::iee_back_status_t         status_o,
  iee_out_if.source                         result_o
);
  import iee_pkg::*;

  localparam int IDX_W     = $clog2(MAX_SPINS);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  iee_state_e                   state_q, state_d;
  logic [ADDR_W-1:0]            clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0]             i_q, i_d, j_q, j_d;
  logic [NUM_SPINS_W-1:0]       n_last_q, n_last_d;
  logic [NUM_SPINS_W-1:0]       n_eff;
  logic [SPIN_W-1:0]            spins_q, spins_d;
  logic signed [ENERGY_W-1:0]   acc_q, acc_d;
  logic signed [ENERGY_W-1:0]   term;
  logic                         pend_q, pend_d;
  logic                         differ_q, differ_d;
  logic signed [COUPLING_W-1:0] rdata_q;
  logic                         out_valid_q, out_valid_d;
  logic signed [ENERGY_W-1:0]   energy_q, energy_d;

  logic signed [COUPLING_W-1:0] mem [MEM_DEPTH];
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic signed [COUPLING_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]            mem_raddr;

  // active spin count, clamped to the store size
  assign n_eff = (num_spins_i > NUM_SPINS_W'(MAX_SPINS)) ? NUM_SPINS_W'(MAX_SPINS)
                                                        : num_spins_i;

  assign mem_raddr = {i_q, j_q};

  // coupling term: equal spins subtract the coupling, opposite spins add it
  assign term = differ_q ? ENERGY_W'(rdata_q) : -ENERGY_W'(rdata_q);

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign result_o.valid    = out_valid_q;
  assign result_o.energy   = energy_q;

  // sequencer next state and datapath control
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    n_last_d    = n_last_q;
    spins_d     = spins_q;
    acc_d       = pend_q ? acc_q + term : acc_q;
    pend_d      = 1'b0;
    differ_d    = spins_q[SPIN_IDX_W'(i_q)] ^ spins_q[SPIN_IDX_W'(j_q)];
    out_valid_d = out_valid_q && !result_o.ready;
    energy_d    = energy_q;
    q_ready_o   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = {q_item_i.row[IDX_W-1:0], q_item_i.col[IDX_W-1:0]};
    mem_wdata   = q_item_i.value;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (q_item_i.is_eval) begin
            spins_d  = q_item_i.spins;
            n_last_d = n_eff - 1'b1;
            i_d      = '0;
            j_d      = IDX_W'(1);
            acc_d    = '0;
            state_d  = (n_eff < NUM_SPINS_W'(2)) ? ST_DONE : ST_EVAL;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_EVAL: begin
        // one upper-triangle read per cycle
        pend_d = 1'b1;
        if (NUM_SPINS_W'(j_q) == n_last_q) begin
          if (NUM_SPINS_W'(i_q) == n_last_q - 1'b1) begin
            state_d = ST_DRAIN;
          end
          i_d = i_q + 1'b1;
          j_d = i_q + IDX_W'(2);
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          energy_d    = acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    n_last_q <= n_last_d;
    spins_q  <= spins_d;
    acc_q    <= acc_d;
    differ_q <= differ_d;
    energy_q <= energy_d;
  end

  // coupling store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

endmodule

/* sv/ising_energy_evaluator_unit.sv */
// top level of the ising energy evaluator
// a write item is stored by the back end when taken; an evaluation reads the coupling store
// once per upper-triangle pair, one read per cycle, and reads nothing below two spins
// items follow one another; a two-entry queue lets new items wait while one executes
// after reset the store is cleared one entry a cycle, all 4096 entries at 64 spins,
// during which no item is taken; num_spins resets to 64 and is writable at any time
module ising_energy_evaluator_unit #(
  parameter int MAX_SPINS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  iee_in_if.sink                           item_i,
  iee_out_if.source                        result_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [iee_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [iee_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [iee_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import iee_pkg::*;

  logic [NUM_SPINS_W-1:0] num_spins_q;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_write;

  iee_back_status_t       status;
  logic                   push_valid, push_ready;
  iee_item_t              push_item;
  logic                   pop_valid, pop_ready;
  iee_item_t              pop_item;

  // configuration register access
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (reg_idx == REG_NUM_SPINS) ? APB_DATA_W'(num_spins_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_spins_q <= NUM_SPINS_RESET;
    end else if (cfg_write && (reg_idx == REG_NUM_SPINS)) begin
      num_spins_q <= pwdata[NUM_SPINS_W-1:0];
    end
  end

  iee_front #(
    .MAX_SPINS (MAX_SPINS)
  ) u_front (
    .item_i       (item_i),
    .status_i     (status),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  iee_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  iee_back #(
    .MAX_SPINS (MAX_SPINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .num_spins_i (num_spins_q),
    .q_valid_i   (pop_valid),
    .q_item_i    (pop_item),
    .q_ready_o   (pop_ready),
    .status_o    (status),
    .result_o    (result_o)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench of the ising energy evaluator with a local energy predictor
module tb_top;
  import iee_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int SPINS        = 64;
  localparam int TAIL_CYCLES  = 32;
  localparam int RUN_LIMIT    = 2_000_000;
  localparam int RANDOM_ITEMS = 270;
  // register index with nothing behind it
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  iee_in_if  item_if ();
  iee_out_if result_if ();

  ising_energy_evaluator_unit #(
    .MAX_SPINS(SPINS)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the coupling store and the spin count
  logic signed [COUPLING_W-1:0] coupling_mem [SPINS*SPINS];
  logic [NUM_SPINS_W-1:0]       active_spins;
  logic signed [ENERGY_W-1:0]   pending_energy [$];

  int error_count   = 0;
  int write_count   = 0;
  int eval_count    = 0;
  int checked_count = 0;
  int cycle_count   = 0;
  int pending_gap   = 0;
  bit no_idle       = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("ising_energy_evaluator_unit regression: fail");
      $finish;
    end
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // energy of a spin vector over the active upper triangle
  function automatic logic signed [ENERGY_W-1:0] ising_energy(input logic [SPIN_W-1:0] spins);
    int limit;
    int total;
    limit = (int'(active_spins) > SPINS) ? SPINS : int'(active_spins);
    total = 0;
    for (int i = 0; i < limit; i++) begin
      for (int j = i + 1; j < limit; j++) begin
        if (spins[i] == spins[j]) total -= int'(coupling_mem[i*SPINS+j]);
        else total += int'(coupling_mem[i*SPINS+j]);
      end
    end
    return total[ENERGY_W-1:0];
  endfunction

  // update the store or queue the expected energy of an accepted transaction
  task automatic absorb_item(input logic [OPCODE_W-1:0] op, input logic [IDX_FIELD_W-1:0] row,
                             input logic [IDX_FIELD_W-1:0] col,
                             input logic signed [COUPLING_W-1:0] value,
                             input logic [SPIN_W-1:0] spins);
    if (op == OP_WRITE) begin
      coupling_mem[{row, col}] = value;
      write_count++;
    end else begin
      pending_energy.push_back(ising_energy(spins));
      eval_count++;
    end
  endtask

  // drive one transaction and wait for its acceptance
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [IDX_FIELD_W-1:0] row,
                           input logic [IDX_FIELD_W-1:0] col,
                           input logic signed [COUPLING_W-1:0] value,
                           input logic [SPIN_W-1:0] spins);
    repeat (pending_gap) @(posedge clk_i);
    item_if.valid          <= 1'b1;
    item_if.opcode         <= op;
    item_if.row_index      <= row;
    item_if.col_index      <= col;
    item_if.coupling_value <= value;
    item_if.spin_bits      <= spins;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    absorb_item(op, row, col, value, spins);
    // valid stays up when the next transaction follows at once
    pending_gap = draw_wait();
    if (pending_gap != 0) item_if.valid <= 1'b0;
  endtask

  // stop the stream and let every expected energy arrive
  task automatic drain_block();
    if (pending_gap == 0) item_if.valid <= 1'b0;
    while (pending_energy.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_NUM_SPINS) active_spins = data[NUM_SPINS_W-1:0];
  endtask

  task automatic cfg_read_check();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_NUM_SPINS, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== APB_DATA_W'(active_spins)) begin
      $display("%0t: num_spins readback mismatch, expected %0d, got %0d",
               $time, active_spins, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random stalls, compare each energy with the oldest expectation
  initial begin : energy_sink
    int stall;
    logic signed [ENERGY_W-1:0] want;
    result_if.ready = 1'b0;
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
      if (pending_energy.size() == 0) begin
        $display("%0t: energy %0d with none expected", $time, result_if.energy);
        error_count++;
      end else begin
        want = pending_energy.pop_front();
        checked_count++;
        if (result_if.energy !== want) begin
          $display("%0t: energy mismatch, expected %0d, got %0d", $time, want, result_if.energy);
          error_count++;
        end
      end
    end
  end

  // empty store and reset spin count
  task automatic test_reset_values();
    cfg_read_check();
    send_item(OP_EVAL, 6'd0, 6'd0, 16'sh0000, '1);
    send_item(OP_EVAL, 6'd63, 6'd63, 16'shFFFF, 64'h0123_4567_89AB_CDEF);
    drain_block();
  endtask

  // coupling extremes, ignored diagonal and lower triangle, overwrite
  task automatic test_coupling_extremes();
    send_item(OP_WRITE, 6'd0, 6'd1, 16'sh7FFF, '0);
    send_item(OP_WRITE, 6'd0, 6'd63, 16'sh8000, '1);
    send_item(OP_WRITE, 6'd62, 6'd63, 16'shFFFF, {$urandom, $urandom});
    send_item(OP_WRITE, 6'd1, 6'd0, 16'sh1234, {$urandom, $urandom});
    send_item(OP_WRITE, 6'd7, 6'd7, 16'sh0BAD, {$urandom, $urandom});
    send_item(OP_WRITE, 6'd63, 6'd62, 16'sh4000, '1);
    send_item(OP_WRITE, 6'd2, 6'd3, 16'sh5A5A, '1);
    send_item(OP_EVAL, 6'd0, 6'd0, 16'sh0000, '1);
    send_item(OP_EVAL, 6'd0, 6'd0, 16'sh0000, '0);
    send_item(OP_EVAL, 6'd0, 6'd0, 16'sh0000, {4{16'hAAAA}});
    send_item(OP_EVAL, 6'd0, 6'd0, 16'sh0000, {4{16'h5555}});
    send_item(OP_EVAL, 6'd0, 6'd0, 16'sh0000, 64'h8000_0000_0000_0001);
    send_item(OP_EVAL, 6'd63, 6'd63, 16'sh7FFF, {$urandom, $urandom});
    send_item(OP_WRITE, 6'd0, 6'd1, 16'sh8001, '0);
    send_item(OP_EVAL, 6'd0, 6'd0, 16'sh0000, '1);
    drain_block();
  endtask

  // spin counts below two, above the store size, junk in upper data bits, spare register
  task automatic test_spin_counts();
    logic [APB_DATA_W-1:0] settings [7];
    settings = '{32'd0, 32'd1, 32'd2, 32'd127, 32'd65, 32'hFFFF_FF83, 32'd64};
    foreach (settings[k]) begin
      drain_block();
      cfg_write(REG_NUM_SPINS, settings[k]);
      cfg_read_check();
      if (settings[k] == 32'hFFFF_FF83) begin
        cfg_write(REG_SPARE, 32'd5);
        cfg_read_check();
      end
      send_item(OP_EVAL, 6'd0, 6'd0, 16'sh0000, {$urandom, $urandom});
    end
    drain_block();
  endtask

  // random phases, each with its own spin count and idle pattern
  task automatic test_random_traffic(input int total);
    int sent;
    int phase_len;
    int span;
    int eval_odds;
    logic [NUM_SPINS_W-1:0] setting;
    logic [IDX_FIELD_W-1:0] row;
    logic [IDX_FIELD_W-1:0] col;
    sent = 0;
    while (sent < total) begin
      case ($urandom_range(0, 9))
        0: setting = 7'd64;
        1: setting = 7'($urandom_range(65, 127));
        2: setting = 7'($urandom_range(0, 1));
        default: setting = 7'($urandom_range(2, 20));
      endcase
      drain_block();
      cfg_write(REG_NUM_SPINS, APB_DATA_W'(setting));
      cfg_read_check();
      no_idle   = ($urandom_range(0, 3) == 0);
      span      = (setting > 7'd64) ? SPINS : ((setting < 7'd2) ? 2 : int'(setting));
      // long evaluations are kept rare at large spin counts
      eval_odds = (span > 24) ? 8 : 4;
      phase_len = $urandom_range(25, 45);
      for (int k = 0; k < phase_len && sent < total; k++) begin
        if ($urandom_range(1, eval_odds) == 1) begin
          send_item(OP_EVAL, 6'($urandom), 6'($urandom), 16'($urandom), {$urandom, $urandom});
        end else if ($urandom_range(0, 6) == 0) begin
          // anywhere in the store, mostly outside the active spins
          send_item(OP_WRITE, 6'($urandom), 6'($urandom), 16'($urandom), {$urandom, $urandom});
        end else begin
          row = 6'($urandom_range(0, span - 1));
          col = 6'($urandom_range(0, span - 1));
          send_item(OP_WRITE, row, col, 16'($urandom), {$urandom, $urandom});
        end
        sent++;
      end
    end
    drain_block();
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    item_if.valid          = 1'b0;
    item_if.opcode         = OP_WRITE;
    item_if.row_index      = '0;
    item_if.col_index      = '0;
    item_if.coupling_value = '0;
    item_if.spin_bits      = '0;
    active_spins           = NUM_SPINS_RESET;
    foreach (coupling_mem[k]) coupling_mem[k] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_coupling_extremes();
    test_spin_counts();
    test_random_traffic(RANDOM_ITEMS);

    $display("covered %0d coupling writes and %0d evaluations, %0d energies compared",
             write_count, eval_count, checked_count);
    $display("spin counts 0 to 127 with idle and stall gaps of 0 to 15 cycles on both channels");
    if (error_count == 0) begin
      $display("ising_energy_evaluator_unit regression: pass");
    end else begin
      $display("ising_energy_evaluator_unit regression: fail");
    end
    $finish;
  end

endmodule

/* ising_energy_evaluator_unit.f */
sv/iee_pkg.sv
sv/iee_in_if.sv
sv/iee_out_if.sv
sv/iee_front.sv
sv/iee_queue.sv
sv/iee_back.sv
sv/ising_energy_evaluator_unit.sv
tb/sv/tb_top.sv
